// ----- rtl/hdu_pkg.sv -----
// Shared types, command codes and default sizes for the half-duplex UART buffers.
`default_nettype none
package hdu_pkg;

  localparam int HDU_DEPTH = 32;

  typedef enum logic [2:0] {
    CMD_LINE_RX   = 3'd0,
    CMD_TX_READY  = 3'd1,
    CMD_TX_DONE   = 3'd2,
    CMD_HOST_WR   = 3'd3,
    CMD_HOST_RD   = 3'd4
  } hdu_cmd_t;

  typedef struct packed {
    logic       line_valid;
    logic [7:0] line_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       accepted;
    logic       drive_enable;
    logic       tx_events_enabled;
    logic       restart_timeout;
    logic [4:0] rx_level;
    logic [4:0] tx_level;
  } hdu_result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // an item is accepted this cycle
    logic fill;  // the popped byte is ready to be merged into the result
  } hdu_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pop_hit;  // the current item pops a byte out of a buffer
  } hdu_stat_t;

endpackage
`default_nettype wire

// ----- rtl/hdu_in_if.sv -----
// Input channel interface: one event item per handshake.
`default_nettype none
interface hdu_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] data_in;

  modport source (output valid, output command, output data_in, input ready);
  modport sink (input valid, input command, input data_in, output ready);
endinterface
`default_nettype wire

// ----- rtl/hdu_out_if.sv -----
// Output channel interface: one result item per handshake.
`default_nettype none
interface hdu_out_if;
  logic       valid;
  logic       ready;
  logic       line_valid;
  logic [7:0] line_byte;
  logic       read_valid;
  logic [7:0] read_byte;
  logic       accepted;
  logic       drive_enable;
  logic       tx_events_enabled;
  logic       restart_timeout;
  logic [4:0] rx_level;
  logic [4:0] tx_level;

  modport source (output valid, output line_valid, output line_byte, output read_valid,
                  output read_byte, output accepted, output drive_enable,
                  output tx_events_enabled, output restart_timeout, output rx_level,
                  output tx_level, input ready);
  modport sink (input valid, input line_valid, input line_byte, input read_valid,
                input read_byte, input accepted, input drive_enable,
                input tx_events_enabled, input restart_timeout, input rx_level,
                input tx_level, output ready);
endinterface
`default_nettype wire

// ----- rtl/hdu_dp.sv -----
// Datapath: both ring buffers, their indices, line direction state and the result register.
`default_nettype none
module hdu_dp #(
  parameter int DEPTH = hdu_pkg::HDU_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [2:0]          command,
  input  wire logic [7:0]          data_in,
  input  wire hdu_pkg::hdu_ctrl_t  ctrl,
  output hdu_pkg::hdu_stat_t       stat,
  output hdu_pkg::hdu_result_t     res
);
  import hdu_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = (AW + 1 > 5) ? AW + 1 : 5;

  logic [7:0]    rx_mem [DEPTH];
  logic [7:0]    tx_mem [DEPTH];
  logic [7:0]    rx_q;
  logic [7:0]    tx_q;
  logic [AW-1:0] rx_wr, rx_rd, tx_wr, tx_rd;
  logic [AW-1:0] rx_wr_next, rx_rd_next, tx_wr_next, tx_rd_next;
  logic          send_mode, send_mode_next;
  logic          events_on, events_on_next;
  logic          rx_we, tx_we;
  logic          rx_empty, rx_full, tx_empty, tx_full;
  hdu_result_t   res_next;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [4:0] level(input logic [AW-1:0] wr, input logic [AW-1:0] rd);
    logic [AW:0]   d;
    logic [FW-1:0] e;
    if (wr >= rd) begin
      d = {1'b0, wr} - {1'b0, rd};
    end else begin
      d = {1'b0, wr} + (AW + 1)'(DEPTH) - {1'b0, rd};
    end
    e = FW'(d);
    return e[4:0];
  endfunction

  assign rx_empty = (rx_wr == rx_rd);
  assign tx_empty = (tx_wr == tx_rd);
  assign rx_full  = (next_slot(rx_wr) == rx_rd);
  assign tx_full  = (next_slot(tx_wr) == tx_rd);

  assign stat.pop_hit = ((command == CMD_TX_READY) && !tx_empty) ||
                        ((command == CMD_HOST_RD) && !rx_empty);

  always_comb begin
    rx_wr_next     = rx_wr;
    rx_rd_next     = rx_rd;
    tx_wr_next     = tx_wr;
    tx_rd_next     = tx_rd;
    send_mode_next = send_mode;
    events_on_next = events_on;
    rx_we          = 1'b0;
    tx_we          = 1'b0;
    res_next       = '0;
    case (hdu_cmd_t'(command))
      CMD_LINE_RX: begin
        // Bytes seen while driving the line are our own echo.
        if (!send_mode) begin
          res_next.restart_timeout = 1'b1;
          if (!rx_full) begin
            rx_we             = 1'b1;
            rx_wr_next        = next_slot(rx_wr);
            res_next.accepted = 1'b1;
          end
        end
      end
      CMD_TX_READY: begin
        if (!tx_empty) begin
          send_mode_next      = 1'b1;
          res_next.line_valid = 1'b1;
          tx_rd_next          = next_slot(tx_rd);
        end else begin
          events_on_next = 1'b0;
        end
      end
      CMD_TX_DONE: begin
        if (tx_empty) begin
          send_mode_next = 1'b0;
        end
      end
      CMD_HOST_WR: begin
        if (!tx_full) begin
          tx_we             = 1'b1;
          tx_wr_next        = next_slot(tx_wr);
          events_on_next    = 1'b1;
          res_next.accepted = 1'b1;
        end
      end
      CMD_HOST_RD: begin
        if (!rx_empty) begin
          res_next.read_valid = 1'b1;
          rx_rd_next          = next_slot(rx_rd);
        end
      end
      default: begin
      end
    endcase
    res_next.drive_enable      = send_mode_next;
    res_next.tx_events_enabled = events_on_next;
    res_next.rx_level          = level(rx_wr_next, rx_rd_next);
    res_next.tx_level          = level(tx_wr_next, tx_rd_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_wr     <= '0;
      rx_rd     <= '0;
      tx_wr     <= '0;
      tx_rd     <= '0;
      send_mode <= 1'b0;
      events_on <= 1'b1;
    end else if (ctrl.load) begin
      rx_wr     <= rx_wr_next;
      rx_rd     <= rx_rd_next;
      tx_wr     <= tx_wr_next;
      tx_rd     <= tx_rd_next;
      send_mode <= send_mode_next;
      events_on <= events_on_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load && rx_we) begin
      rx_mem[rx_wr] <= data_in;
    end
    if (ctrl.load) begin
      rx_q <= rx_mem[rx_rd];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load && tx_we) begin
      tx_mem[tx_wr] <= data_in;
    end
    if (ctrl.load) begin
      tx_q <= tx_mem[tx_rd];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      res <= res_next;
    end else if (ctrl.fill) begin
      if (res.line_valid) begin
        res.line_byte <= tx_q;
      end
      if (res.read_valid) begin
        res.read_byte <= rx_q;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hdu_ctrl.sv -----
// Controller: handshakes on both channels and sequencing of buffer reads.
`default_nettype none
module hdu_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire hdu_pkg::hdu_stat_t stat,
  output hdu_pkg::hdu_ctrl_t      ctrl
);
  import hdu_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_FETCH
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign ctrl.load = accept;
  assign ctrl.fill = (state == S_FETCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (stat.pop_hit) begin
              // The popped byte arrives from the buffer memory next cycle.
              state     <= S_FETCH;
              out_valid <= 1'b0;
            end else begin
              out_valid <= 1'b1;
            end
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_FETCH: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: begin
          state     <= S_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/half_duplex_uart_ring_buffers_unit.sv -----
// Top level of the half-duplex RS485 UART byte buffers.
//
// The request channel carries one event item per handshake: a byte from the
// line, a transmit-ready or transmit-complete event, a host write or a host
// read. Every accepted item yields exactly one item on the result channel.
// Items that only touch indices or store a byte produce their result in the
// cycle after acceptance. Items that pop a byte (transmit ready with data
// queued, host read with data waiting) pass through a fetch state, because
// the byte is read from the buffer memory through a registered read port
// and is merged into the result register there. No new item is accepted
// while a pop is in the fetch state.
// The result sits in an output register; while it waits, the next item can
// still be accepted in the same cycle it is taken. When the receiver stalls
// the result channel, the request channel is held off until the pending
// result is taken.
// Reset empties both buffers, selects receive mode and enables transmit-ready
// events. Buffer contents are not cleared; the one-empty-slot rule means a
// slot is never popped before it was written.
`default_nettype none
module half_duplex_uart_ring_buffers_unit #(
  parameter int DEPTH = hdu_pkg::HDU_DEPTH
) (
  input wire logic clk,
  input wire logic rst,
  hdu_in_if.sink   request,
  hdu_out_if.source result
);
  import hdu_pkg::*;

  hdu_ctrl_t   ctrl;
  hdu_stat_t   stat;
  hdu_result_t res;

  // Controller: owns the handshakes and the fetch state of a pop.
  hdu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // Datapath: buffer memories, indices, direction state and result register.
  hdu_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .command (request.command),
    .data_in (request.data_in),
    .ctrl    (ctrl),
    .stat    (stat),
    .res     (res)
  );

  assign result.line_valid        = res.line_valid;
  assign result.line_byte         = res.line_byte;
  assign result.read_valid        = res.read_valid;
  assign result.read_byte         = res.read_byte;
  assign result.accepted          = res.accepted;
  assign result.drive_enable      = res.drive_enable;
  assign result.tx_events_enabled = res.tx_events_enabled;
  assign result.restart_timeout   = res.restart_timeout;
  assign result.rx_level          = res.rx_level;
  assign result.tx_level          = res.tx_level;

endmodule
`default_nettype wire

// ----- rtl/hdu_checker.sv -----
// Port-level checks for the half-duplex UART buffers, bound to the top level.
`default_nettype none
module hdu_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic line_valid,
  input wire logic read_valid,
  input wire logic accepted,
  input wire logic drive_enable,
  input wire logic restart_timeout
);

  // A result that is not taken stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Handing a byte to the line always leaves the driver in send mode.
  a_send_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_valid |-> drive_enable)
    else $error("line byte without send mode");

  // A timeout restart only comes from a line byte taken in receive mode.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    out_valid && restart_timeout |-> !drive_enable && !line_valid && !read_valid)
    else $error("timeout restart in wrong context");

  // A pop never also stores a byte.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && (line_valid || read_valid) |-> !accepted && !(line_valid && read_valid))
    else $error("pop combined with store");

endmodule

bind half_duplex_uart_ring_buffers_unit hdu_checker u_hdu_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .line_valid      (result.line_valid),
  .read_valid      (result.read_valid),
  .accepted        (result.accepted),
  .drive_enable    (result.drive_enable),
  .restart_timeout (result.restart_timeout)
);
`default_nettype wire
